/* rtl/core/assert_macros.svh */
// Assertion macros shared by the console RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define TCW_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// Depends on nothing; used by the front end, job queue, screen engine and top level.
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS_DEF    = 80;
	localparam int ROWS_DEF       = 25;
	localparam int ADDR_MAX_W     = 13;
	localparam int JOB_FIFO_DEPTH = 2;

	localparam logic [7:0]  BLANK_CHAR   = 8'h20;
	localparam logic [7:0]  DEFAULT_ATTR = 8'h0F;
	localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
	localparam logic [15:0] BLANK_CELL   = {DEFAULT_ATTR, BLANK_CHAR};

	typedef enum logic [2:0] {
		OP_PUT    = 3'd0,
		OP_COLOR  = 3'd1,
		OP_CURSOR = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		JOB_NONE  = 2'd0,
		JOB_WRITE = 2'd1,
		JOB_READ  = 2'd2,
		JOB_CLEAR = 2'd3
	} job_kind_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] character;
		logic [3:0] foreground;
		logic [3:0] background;
		logic [4:0] target_row;
		logic [6:0] target_column;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  current_row;
		logic [6:0]  current_column;
		logic [15:0] cell_word;
		logic        did_scroll;
	} rsp_t;

	typedef struct packed {
		job_kind_t               kind;
		logic [ADDR_MAX_W-1:0]   addr;
		logic [15:0]             data;
		logic [7:0]              fill_attr;
		logic [4:0]              current_row;
		logic [6:0]              current_column;
		logic                    did_scroll;
	} job_t;

endpackage

/* rtl/core/tcw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/tcw_job_fifo.sv */
// Short job queue between the command front end and the screen engine.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::job_t wjob,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output tcw_pkg::job_t head
);

	localparam int DEPTH = tcw_pkg::JOB_FIFO_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	tcw_pkg::job_t   mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wjob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

/* rtl/core/tcw_front.sv */
// Command front end: keeps cursor and attribute, turns each command into a screen job.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          init_done,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tcw_pkg::cmd_t cmd,
	output logic          job_push,
	input  logic          job_full,
	output tcw_pkg::job_t job
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);
	localparam int AW = $clog2(ROWS * COLUMNS);

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [7:0]    attr_q;

	logic [RW:0]   row_inc;
	logic [CW:0]   col_inc;
	logic [RW-1:0] row_sat;
	logic [CW-1:0] col_sat;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] tgt_addr;
	logic [RW-1:0] row_n;
	logic [CW-1:0] col_n;
	logic [7:0]    attr_n;
	logic          row_adv;
	logic          scroll;

	assign cmd_ready = init_done && !job_full;
	assign job_push  = cmd_valid && cmd_ready;

	assign row_inc  = {1'b0, row_q} + (RW + 1)'(1);
	assign col_inc  = {1'b0, col_q} + (CW + 1)'(1);
	assign row_sat  = (32'(cmd.target_row) >= ROWS) ? RW'(ROWS - 1) : RW'(cmd.target_row);
	assign col_sat  = (32'(cmd.target_column) >= COLUMNS) ?
		CW'(COLUMNS - 1) : CW'(cmd.target_column);
	assign cur_addr = AW'(row_q * COLUMNS) + AW'(col_q);
	assign tgt_addr = AW'(row_sat * COLUMNS) + AW'(col_sat);

	always_comb begin
		row_n   = row_q;
		col_n   = col_q;
		attr_n  = attr_q;
		row_adv = 1'b0;
		scroll  = 1'b0;
		job     = '0;
		job.kind      = tcw_pkg::JOB_NONE;
		job.fill_attr = attr_q;
		case (cmd.op)
			tcw_pkg::OP_PUT: begin
				if (cmd.character == tcw_pkg::NEWLINE_CHAR) begin
					col_n   = '0;
					row_adv = 1'b1;
				end else begin
					job.kind = tcw_pkg::JOB_WRITE;
					job.addr = tcw_pkg::ADDR_MAX_W'(cur_addr);
					job.data = {attr_q, cmd.character};
					if (col_inc == (CW + 1)'(COLUMNS)) begin
						col_n   = '0;
						row_adv = 1'b1;
					end else begin
						col_n = col_inc[CW-1:0];
					end
				end
				if (row_adv) begin
					if (row_inc == (RW + 1)'(ROWS)) begin
						scroll = 1'b1;
						row_n  = RW'(ROWS - 1);
					end else begin
						row_n = row_inc[RW-1:0];
					end
				end
			end
			tcw_pkg::OP_COLOR: begin
				attr_n = {cmd.background, cmd.foreground};
			end
			tcw_pkg::OP_CURSOR: begin
				row_n = row_sat;
				col_n = col_sat;
			end
			tcw_pkg::OP_CLEAR: begin
				job.kind = tcw_pkg::JOB_CLEAR;
				attr_n   = tcw_pkg::DEFAULT_ATTR;
				row_n    = '0;
				col_n    = '0;
			end
			tcw_pkg::OP_READ: begin
				job.kind = tcw_pkg::JOB_READ;
				job.addr = tcw_pkg::ADDR_MAX_W'(tgt_addr);
			end
			default: begin
			end
		endcase
		job.did_scroll     = scroll;
		job.current_row    = 5'(row_n);
		job.current_column = 7'(col_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			attr_q <= tcw_pkg::DEFAULT_ATTR;
		end else if (job_push) begin
			row_q  <= row_n;
			col_q  <= col_n;
			attr_q <= attr_n;
		end
	end

endmodule

/* rtl/core/tcw_back.sv */
// Screen engine: runs queued jobs against the cell store and returns one response each.
// Depends on tcw_pkg, tcw_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          init_done,
	input  logic          job_valid,
	input  tcw_pkg::job_t job,
	output logic          job_pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tcw_pkg::rsp_t rsp
);

	localparam int N  = ROWS * COLUMNS;
	localparam int AW = $clog2(N);
	localparam logic [AW-1:0] LAST     = AW'(N - 1);
	localparam logic [AW-1:0] COPY_END = AW'(N - COLUMNS);

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_READ = 5'b00100,
		ST_COPY = 5'b01000,
		ST_FILL = 5'b10000
	} state_t;

	state_t        state_q;
	state_t        state_n;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] cnt_n;
	logic [AW-1:0] wa_q;
	logic [AW-1:0] wa_n;
	logic          rd_pend_q;
	logic          rd_pend_n;
	logic [15:0]   fill_q;
	logic [15:0]   fill_n;
	logic [4:0]    res_row_q;
	logic [6:0]    res_col_q;
	logic          res_scroll_q;
	logic          rsp_valid_q;
	tcw_pkg::rsp_t rsp_q;
	tcw_pkg::rsp_t rsp_n;
	logic          load_rsp;
	logic          out_free;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(N)
	) u_cells (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign init_done = (state_q != ST_INIT);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		wa_n      = wa_q;
		rd_pend_n = rd_pend_q;
		fill_n    = fill_q;
		we        = 1'b0;
		waddr     = cnt_q;
		wdata     = fill_q;
		raddr     = job.addr[AW-1:0];
		job_pop   = 1'b0;
		load_rsp  = 1'b0;
		rsp_n.current_row    = res_row_q;
		rsp_n.current_column = res_col_q;
		rsp_n.did_scroll     = res_scroll_q;
		rsp_n.cell_word      = '0;
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = tcw_pkg::BLANK_CELL;
				if (cnt_q == LAST) begin
					cnt_n   = '0;
					state_n = ST_IDLE;
				end else begin
					cnt_n = cnt_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (job_valid && out_free) begin
					job_pop              = 1'b1;
					rsp_n.current_row    = job.current_row;
					rsp_n.current_column = job.current_column;
					rsp_n.did_scroll     = job.did_scroll;
					case (job.kind)
						tcw_pkg::JOB_WRITE: begin
							we       = 1'b1;
							waddr    = job.addr[AW-1:0];
							wdata    = job.data;
							load_rsp = !job.did_scroll;
						end
						tcw_pkg::JOB_READ: begin
							state_n = ST_READ;
						end
						tcw_pkg::JOB_CLEAR: begin
							cnt_n   = '0;
							fill_n  = tcw_pkg::BLANK_CELL;
							state_n = ST_FILL;
						end
						default: begin
							load_rsp = !job.did_scroll;
						end
					endcase
					if (job.did_scroll) begin
						cnt_n     = '0;
						rd_pend_n = 1'b0;
						fill_n    = {job.fill_attr, tcw_pkg::BLANK_CHAR};
						state_n   = ST_COPY;
					end
				end
			end
			ST_READ: begin
				load_rsp        = 1'b1;
				rsp_n.cell_word = rdata;
				state_n         = ST_IDLE;
			end
			ST_COPY: begin
				we    = rd_pend_q;
				waddr = wa_q;
				wdata = rdata;
				if (cnt_q != COPY_END) begin
					raddr     = cnt_q + AW'(COLUMNS);
					rd_pend_n = 1'b1;
					wa_n      = cnt_q;
					cnt_n     = cnt_q + AW'(1);
				end else begin
					rd_pend_n = 1'b0;
					state_n   = ST_FILL;
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (cnt_q == LAST) begin
					load_rsp = 1'b1;
					state_n  = ST_IDLE;
				end else begin
					cnt_n = cnt_q + AW'(1);
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		wa_q   <= wa_n;
		fill_q <= fill_n;
		if (job_pop) begin
			res_row_q    <= job.current_row;
			res_col_q    <= job.current_column;
			res_scroll_q <= job.did_scroll;
		end
		if (load_rsp) begin
			rsp_q <= rsp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			cnt_q     <= cnt_n;
			rd_pend_q <= rd_pend_n;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`TCW_NEVER(a_busy_no_rsp, clk, arst_n, rsp_valid_q && (state_q == ST_READ || state_q == ST_COPY || state_q == ST_FILL), "Response held while a job is in progress.")
	`TCW_ASSERT(a_read_done, clk, arst_n, state_q == ST_READ |=> state_q == ST_IDLE && rsp_valid_q, "Cell read did not complete in one cycle.")
	`TCW_ASSERT(a_fill_done, clk, arst_n, state_q == ST_FILL && cnt_q == LAST |=> state_q == ST_IDLE && rsp_valid_q, "Fill sweep ended without a response.")
	`TCW_NEVER(a_copy_range, clk, arst_n, state_q == ST_COPY && rd_pend_q && wa_q >= COPY_END, "Scroll copy wrote into the bottom row.")

endmodule

/* rtl/core/text_console_writer_core.sv */
// Top level of the text console writer: front end, job queue and screen engine.
// Depends on tcw_pkg, tcw_front, tcw_job_fifo and tcw_back.
`timescale 1ns / 1ps

// Character-cell console with a ROWS x COLUMNS screen store, one response per command.
// After reset the store is swept to blank cells, during which cmd_ready stays low. The
// front end takes one command per cycle, while the queue has room, into a two-entry queue;
// the engine then handles a put, set-color, set-cursor or unused code straight from idle,
// a read through a read state (registered RAM port), a clear through a fill of the whole
// store and a scrolling put through a row copy and a bottom-row fill; the single-write-port
// cell store is swept one cell per cycle. While a response waits on rsp_ready the engine
// holds the next job, and the front end keeps accepting commands until the queue is full.
module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tcw_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tcw_pkg::rsp_t rsp
);

	logic          init_done;
	logic          job_push;
	logic          job_full;
	logic          job_empty;
	logic          job_pop;
	tcw_pkg::job_t job_in;
	tcw_pkg::job_t job_head;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.init_done(init_done),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_in)
	);

	tcw_job_fifo u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wjob  (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.empty (job_empty),
		.head  (job_head)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.init_done(init_done),
		.job_valid(!job_empty),
		.job      (job_head),
		.job_pop  (job_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
